// File: sv/two_level_page_walk_unit_defines.svh
// Assertion macros used by the page walk unit's checker file.
`ifndef TWO_LEVEL_PAGE_WALK_UNIT_DEFINES_SVH
`define TWO_LEVEL_PAGE_WALK_UNIT_DEFINES_SVH

// Property checked on every clk edge, muted while rst_n is low.
`define TLPW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clk edge, reset included.
`define TLPW_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/tlpw_pkg.sv
// Shared constants, codes and control types of the page walk unit.
`default_nettype none
package tlpw_pkg;

  localparam int MEM_WORDS_DEF = 4096;
  localparam int IDX_W         = 30;   // word index width before range check
  localparam int DIRF_W        = 20;   // directory frame number width
  localparam int CFG_AW        = 3;

  localparam logic [CFG_AW-1:0] REG_DIR_FRAME = 3'd0;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_XLATE = 1'b1;

  // fault codes
  localparam logic [1:0] FLT_OK  = 2'd0;
  localparam logic [1:0] FLT_DIR = 2'd1;
  localparam logic [1:0] FLT_TBL = 2'd2;
  localparam logic [1:0] FLT_OOB = 2'd3;

  // entry bits
  localparam int ENT_PRESENT = 0;
  localparam int ENT_LARGE   = 7;

  typedef struct packed {
    logic clr;       // clearing pass writes one word
    logic accept;    // take the input transaction
    logic tbl_rd;    // issue the page table read
    logic load_out;  // load the result register
    logic res_tbl;   // result comes from the table entry
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;  // clearing pass at its last word
    logic need_tbl;  // directory entry points at a page table
    logic out_free;  // result register can take a new result
  } ctrl_stat_t;

endpackage
`default_nettype wire

// File: sv/tlpw_ctrl.sv
// Sequencer of the page walk: clearing pass, accept, directory and table steps.
`default_nettype none
module tlpw_ctrl
  import tlpw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire ctrl_stat_t stat,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESOLVE,
    ST_TABLE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (stat.need_tbl) begin
          cmd.tbl_rd = 1'b1;
          state_nxt  = ST_TABLE;
        end else if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_TABLE: begin
        cmd.res_tbl = 1'b1;
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/tlpw_dp.sv
// Entry store, walk registers, range checks and result register.
`default_nettype none
module tlpw_dp
  import tlpw_pkg::*;
#(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ctrl_cmd_t         cmd,
  output ctrl_stat_t             stat,
  input  wire logic [DIRF_W-1:0] dir_frame,
  input  wire logic              in_command,
  input  wire logic [31:0]       in_addr,
  input  wire logic [31:0]       in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [31:0]            out_phys,
  output logic [1:0]             out_fault
);

  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [IDX_W-1:0] LIMIT = IDX_W'(MEM_WORDS);

  logic [31:0]      mem [MEM_WORDS];
  logic [31:0]      rdata_r;
  logic [AW-1:0]    clr_cnt_r;
  logic             cmd_r;
  logic [31:0]      addr_r;
  logic             oob_dir_r, oob_tbl_r;
  logic             out_valid_r;
  logic [31:0]      out_phys_r;
  logic [1:0]       out_fault_r;

  logic [IDX_W-1:0] wr_idx, dir_idx, tbl_idx;
  logic             in_oob, tbl_oob;
  logic [AW-1:0]    mem_addr;
  logic             mem_we, mem_re;
  logic [31:0]      mem_wdata;
  logic [31:0]      res_phys;
  logic [1:0]       res_fault;

  assign wr_idx  = in_addr[31:2];
  assign dir_idx = {dir_frame, in_addr[31:22]};
  assign tbl_idx = {rdata_r[31:12], addr_r[21:12]};
  assign in_oob  = (in_command == CMD_WRITE) ? (wr_idx >= LIMIT) : (dir_idx >= LIMIT);
  assign tbl_oob = (tbl_idx >= LIMIT);

  // single port: clear sweep, accept-time write or directory read, table read
  always_comb begin
    if (cmd.clr) begin
      mem_addr = clr_cnt_r;
    end else if (cmd.accept) begin
      mem_addr = (in_command == CMD_WRITE) ? wr_idx[AW-1:0] : dir_idx[AW-1:0];
    end else begin
      mem_addr = tbl_idx[AW-1:0];
    end
  end

  assign mem_wdata = cmd.clr ? '0 : in_data;
  assign mem_we    = cmd.clr | (cmd.accept & (in_command == CMD_WRITE) & !in_oob);
  assign mem_re    = (cmd.accept & (in_command == CMD_XLATE) & !in_oob) |
                     (cmd.tbl_rd & !tbl_oob);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  // result of the current step
  always_comb begin
    res_phys  = '0;
    res_fault = FLT_OK;
    if (cmd.res_tbl) begin
      if (oob_tbl_r) begin
        res_fault = FLT_OOB;
      end else if (!rdata_r[ENT_PRESENT]) begin
        res_fault = FLT_TBL;
      end else begin
        res_phys = {rdata_r[31:12], addr_r[11:0]};
      end
    end else if (cmd_r == CMD_WRITE) begin
      res_fault = oob_dir_r ? FLT_OOB : FLT_OK;
    end else if (oob_dir_r) begin
      res_fault = FLT_OOB;
    end else if (!rdata_r[ENT_PRESENT]) begin
      res_fault = FLT_DIR;
    end else begin
      res_phys = {rdata_r[31:22], addr_r[21:0]};
    end
  end

  assign stat.clr_last = (clr_cnt_r == AW'(MEM_WORDS - 1));
  assign stat.need_tbl = (cmd_r == CMD_XLATE) & !oob_dir_r &
                         rdata_r[ENT_PRESENT] & !rdata_r[ENT_LARGE];
  assign stat.out_free = !out_valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r     <= in_command;
      addr_r    <= in_addr;
      oob_dir_r <= in_oob;
    end
    if (cmd.tbl_rd) begin
      oob_tbl_r <= tbl_oob;
    end
    if (cmd.load_out) begin
      out_phys_r  <= res_phys;
      out_fault_r <= res_fault;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_phys  = out_phys_r;
  assign out_fault = out_fault_r;

endmodule
`default_nettype wire

// File: sv/two_level_page_walk_unit.sv
// Top level of the two-level page walk unit: ports, directory register, sequencer, datapath.
// Translates 32-bit virtual addresses through a two-level page directory / page table
// held in an internal store of MEM_WORDS 32-bit words, and also fills that store.
// Input transaction: tuser[0] is the command (0 = write a store word at byte address
// addr, 1 = translate addr). Each input transaction yields exactly one output
// transaction {fault, phys_addr}. Directory entries are found at
// dir_frame*4096 + 4*va[31:22]; bit 0 = present, bit 7 = 4 MB page. A 4 KB walk
// reads a second entry at frame(pde)*4096 + 4*va[21:12]. Faults: 1 directory entry
// absent, 2 table entry absent, 3 entry (or write target) beyond the store.
// Timing: the store is single ported with a registered read. A write, a 4 MB hit or a
// directory fault passes through the accept and resolve steps, a 4 KB walk through the
// accept, resolve and table steps. One transaction is in the walk at a time; the
// result register lets the next input be taken while a result waits, and the walk
// stalls in its last step only if the previous result is still not taken.
// After reset the store is swept to zero, one word per cycle, and in_tready stays low
// until the sweep ends; the config port works throughout.
// Config: register 0 (byte address 0) is dir_frame, 20 bits; write only while idle.
`default_nettype none
module two_level_page_walk_unit
  import tlpw_pkg::*;
#(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [63:0]       in_tdata,   // [31:0] addr, [63:32] data
  input  wire logic [0:0]        in_tuser,   // [0] command
  // result channel
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [39:0]            out_tdata,  // [31:0] phys_addr, [33:32] fault, [39:34] zero
  // config port
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  ctrl_cmd_t         cmd;
  ctrl_stat_t        stat;
  logic [DIRF_W-1:0] dir_frame_r;
  logic [31:0]       phys;
  logic [1:0]        fault;
  logic              cfg_wr;

  // directory base register; writes to other addresses are dropped
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_frame_r <= '0;
    end else if (cfg_wr && (cfg_paddr == REG_DIR_FRAME)) begin
      dir_frame_r <= cfg_pwdata[DIRF_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr == REG_DIR_FRAME) ? {{(32-DIRF_W){1'b0}}, dir_frame_r} : '0;

  tlpw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tlpw_dp #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .dir_frame  (dir_frame_r),
    .in_command (in_tuser[0]),
    .in_addr    (in_tdata[31:0]),
    .in_data    (in_tdata[63:32]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_phys   (phys),
    .out_fault  (fault)
  );

  assign out_tdata = {6'b0, fault, phys};

endmodule
`default_nettype wire

// File: sv/tlpw_checker.sv
// Port-level checks of the page walk unit, bound to the top level.
`default_nettype none
`include "two_level_page_walk_unit_defines.svh"
module tlpw_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);

  // one walk at a time: ready drops right after a transaction is taken
  `TLPW_ASSERT(a_one_in_flight, in_tvalid && in_tready |=> !in_tready, "input taken while busy")

  // any fault reports a zero address
  `TLPW_ASSERT(a_fault_zero, out_tvalid && (out_tdata[33:32] != 2'd0) |-> out_tdata[31:0] == 32'd0, "fault with nonzero address")

  // a stalled result holds
  `TLPW_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // clearing pass keeps the input closed after reset
  `TLPW_ASSERT_NR(a_clear_closed, !rst_n |=> !in_tready && !out_tvalid, "ready or valid right after reset")

endmodule

bind two_level_page_walk_unit tlpw_checker u_tlpw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
